[rtl/core/frp_pkg.sv]
`timescale 1ns / 1ps

package frp_pkg;

    // Marker window length in bytes (1 to 8)
    localparam int unsigned MARKER_BYTES = 4;
    localparam int unsigned WIN_W        = 8 * MARKER_BYTES;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes, taken from paddr[2]
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_MAX_PAYLOAD  = 1'b1;

    // Header fields are two bytes each
    localparam logic [15:0] HDR_BYTES = 16'd2;

    typedef struct packed {
        logic [31:0] start_marker;
        logic [15:0] max_payload;
    } frp_cfg_t;

    typedef struct packed {
        logic        frame_start;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_end;
        logic        frame_ok;
        logic        frame_aborted;
    } frp_result_t;

endpackage

[rtl/core/frp_cfg.sv]
`timescale 1ns / 1ps

module frp_cfg
    import frp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output frp_cfg_t              cfg
);

    logic [31:0] start_marker_reg;
    logic [15:0] max_payload_reg;
    logic        wr_req;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_req  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    // Register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= '0;
            max_payload_reg  <= 16'hFFFF;
        end else if (wr_req) begin
            unique case (reg_idx)
                REG_START_MARKER: start_marker_reg <= pwdata[31:0];
                REG_MAX_PAYLOAD:  max_payload_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            REG_START_MARKER: prdata = start_marker_reg;
            REG_MAX_PAYLOAD:  prdata = {16'd0, max_payload_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.start_marker = start_marker_reg;
    assign cfg.max_payload  = max_payload_reg;

endmodule

[rtl/core/frp_engine.sv]
`timescale 1ns / 1ps

module frp_engine
    import frp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  frp_cfg_t    cfg,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output frp_result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_SUM,
        PH_DATA
    } phase_t;

    phase_t            phase_reg,    phase_next;
    logic [WIN_W-1:0]  window_reg,   window_next;
    logic [15:0]       length_reg,   length_next;
    logic [15:0]       checksum_reg, checksum_next;
    logic [15:0]       sum_reg,      sum_next;
    logic [15:0]       left_reg,     left_next;

    logic [WIN_W+7:0]  win_shift;
    logic [WIN_W-1:0]  win_shifted;
    logic [63:0]       marker_ext;
    logic [15:0]       left_dec;
    logic [15:0]       hdr_word;
    logic [15:0]       sum_add;

    assign win_shift   = {window_reg, rx_byte};
    assign win_shifted = win_shift[WIN_W-1:0];
    assign marker_ext  = {32'd0, cfg.start_marker};
    assign left_dec    = left_reg - 16'd1;
    assign sum_add     = sum_reg + {8'd0, rx_byte};

    // Frame state update for one byte
    always_comb begin
        phase_next    = phase_reg;
        window_next   = win_shifted;
        length_next   = length_reg;
        checksum_next = checksum_reg;
        sum_next      = sum_reg;
        left_next     = left_reg;
        result        = '0;
        hdr_word      = '0;

        if (win_shifted == marker_ext[WIN_W-1:0]) begin
            // start marker: restart, window cleared too
            window_next        = '0;
            length_next        = '0;
            checksum_next      = '0;
            sum_next           = '0;
            phase_next         = PH_LEN;
            left_next          = HDR_BYTES;
            result.frame_start = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_LEN: begin
                    hdr_word    = {length_reg[7:0], rx_byte};
                    length_next = hdr_word;
                    left_next   = left_dec;
                    if (left_dec == '0) begin
                        if (hdr_word > cfg.max_payload) begin
                            window_next          = '0;
                            length_next          = '0;
                            checksum_next        = '0;
                            sum_next             = '0;
                            left_next            = '0;
                            phase_next           = PH_IDLE;
                            result.frame_aborted = 1'b1;
                        end else begin
                            phase_next = PH_SUM;
                            left_next  = HDR_BYTES;
                        end
                    end
                end
                PH_SUM: begin
                    hdr_word      = {checksum_reg[7:0], rx_byte};
                    checksum_next = hdr_word;
                    left_next     = left_dec;
                    if (left_dec == '0) begin
                        if (length_reg != '0) begin
                            phase_next = PH_DATA;
                            left_next  = length_reg;
                        end else begin
                            // empty frame: checksum must be zero
                            result.frame_end = 1'b1;
                            result.frame_ok  = (hdr_word == '0);
                            phase_next       = PH_IDLE;
                        end
                    end
                end
                PH_DATA: begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = length_reg - left_reg;
                    sum_next             = sum_add;
                    left_next            = left_dec;
                    if (left_dec == '0) begin
                        // sum plus checksum wraps to zero when they match
                        result.frame_end = 1'b1;
                        result.frame_ok  = ((sum_add + checksum_reg) == '0);
                        phase_next       = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            window_reg   <= '0;
            length_reg   <= '0;
            checksum_reg <= '0;
            sum_reg      <= '0;
            left_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            length_reg   <= length_next;
            checksum_reg <= checksum_next;
            sum_reg      <= sum_next;
            left_reg     <= left_next;
        end
    end

endmodule

[rtl/core/framed_packet_receiver.sv]
`timescale 1ns / 1ps

// Frame receiver: takes one received byte per request on the s_ stream and gives
// exactly one result per byte on the m_ stream. A frame opens when the last
// MARKER_BYTES bytes equal the start_marker register; a big-endian 16-bit length
// and a big-endian 16-bit checksum follow, then the payload bytes, which are passed
// out with their index. The last payload byte (or the checksum byte of an empty
// frame) carries tlast with the checksum verdict; a length above max_payload drops
// the frame and flags it aborted. One byte is taken every clock cycle when the
// output side keeps up; a byte's result is offered on the m_ stream once the byte
// has moved from the input register into the result register. The rate is set by
// the frame state update, which handles one byte per cycle while bytes advance, in
// a single pass of logic.
module framed_packet_receiver
    import frp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] payload_byte, [23:8] payload_index
    output logic [3:0]            m_tuser,   // [0] frame_start, [1] payload_valid,
                                             // [2] frame_ok, [3] frame_aborted
    output logic                  m_tlast,   // frame_end
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    frp_cfg_t    cfg;
    frp_result_t result;
    frp_result_t out_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic        advance;

    frp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // byte moves from the input register into the result register
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    frp_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.payload_index, out_reg.payload_byte};
    assign m_tuser  = {out_reg.frame_aborted, out_reg.frame_ok,
                       out_reg.payload_valid, out_reg.frame_start};
    assign m_tlast  = out_reg.frame_end;

endmodule

[rtl/core/frp_checker.sv]
`timescale 1ns / 1ps

module frp_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [23:0]           m_tdata,
    input logic [3:0]            m_tuser,
    input logic                  m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // the marker byte is never a payload byte
    a_start_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tlast && !m_tuser[3])
        else $error("start marker byte carries other flags");

    // checksum verdict only at frame end
    a_ok_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("frame_ok without frame end");

    // abort is a header byte, never payload or frame end
    a_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> !m_tlast && !m_tuser[1])
        else $error("abort on payload or frame end");

    // payload fields are zero outside payload
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata == 24'd0)
        else $error("payload fields set on a non-payload result");

endmodule

bind framed_packet_receiver frp_checker u_frp_checker (.*);
